// ----- src/lle_pkg.sv -----
package lle_pkg;

  // Field widths
  localparam int unsigned PERIOD_W = 15;  // step period / step timer
  localparam int unsigned OFF_W    = 24;  // auto-off timer, ms
  localparam int unsigned DVS_W    = 8;   // divisor width
  localparam int unsigned CFG_W    = 8;   // config data width
  localparam int unsigned CFG_IDX_W = 3;

  // Step period dividends, ms
  localparam logic [PERIOD_W-1:0] FLASH_DIVIDEND   = 15'd2500;
  localparam logic [PERIOD_W-1:0] FADE_DIVIDEND    = 15'd25000;
  localparam logic [PERIOD_W-1:0] RAINBOW_DIVIDEND = 15'd250;

  localparam logic [15:0] MS_PER_MIN = 16'd60000;
  localparam logic [7:0]  FADE_STEP  = 8'd5;
  localparam logic [7:0]  WHEEL_THIRD     = 8'd85;
  localparam logic [7:0]  WHEEL_TWO_THIRD = 8'd170;

  typedef enum logic [2:0] {
    MODE_OFF     = 3'd0,
    MODE_ON      = 3'd1,
    MODE_FLASH   = 3'd2,
    MODE_FADE    = 3'd3,
    MODE_RAINBOW = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    CMD_TICK       = 2'd0,
    CMD_ACTIVATE   = 2'd1,
    CMD_DEACTIVATE = 2'd2
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LAMP_MODE  = 3'd0,
    REG_BRIGHTNESS = 3'd1,
    REG_SPEED      = 3'd2,
    REG_OFF_DELAY  = 3'd3,
    REG_MIN_FADE   = 3'd4,
    REG_BASE_RED   = 3'd5,
    REG_BASE_GREEN = 3'd6,
    REG_BASE_BLUE  = 3'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_DIV1 = 2'd1,
    ST_DIV2 = 2'd2,
    ST_DONE = 2'd3
  } st_e;

  typedef struct packed {
    logic [1:0] command;
    logic       test_mode;
  } in_word_t;

  typedef struct packed {
    logic       lamp_on;
    logic [2:0] active_mode;
    logic [7:0] out_brightness;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
  } out_word_t;

  typedef struct packed {
    logic                start;
    logic [PERIOD_W-1:0] dividend;
    logic [DVS_W-1:0]    divisor;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [PERIOD_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ----- src/led_lamp_effect_engine.sv -----
// LED lamp effect engine: one word in, one status word out. Commands are a one
// millisecond tick, activate and deactivate; the lamp runs off, on, flash,
// triangular fade or rainbow wheel. Tick, deactivate and an activate that does
// not change mode update the state, then load the result register. An
// activate into flash, rainbow or fade first gets the step period from a
// shared bit-serial divider, run once for flash/rainbow and twice for fade
// ((25000/speed)/max(brightness, min_fade)). in_ready_o is high only while the
// sequencer is idle; a finished word waits in the output register, and the
// next result waits in the done state until that register is free. Config
// writes take effect at once and must only be issued while the block is
// idle; period and auto-off limit are latched at activate. Speed 0 acts as 1.
module led_lamp_effect_engine (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  lle_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output lle_pkg::out_word_t out_word_o,
  input  logic               cfg_we_i,
  input  logic [lle_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [lle_pkg::CFG_W-1:0]     cfg_data_i
);

  localparam int unsigned PW = lle_pkg::PERIOD_W;
  localparam int unsigned OW = lle_pkg::OFF_W;

  // config registers
  logic [2:0] lamp_mode_q;
  logic [7:0] set_bri_q, speed_q, off_delay_q, min_fade_q;
  logic [7:0] base_r_q, base_g_q, base_b_q;

  // lamp state
  lle_pkg::st_e   st_q, st_d;
  lle_pkg::mode_e cur_mode_q, cur_mode_d;
  logic [PW-1:0]  period_q, period_d;
  logic [PW-1:0]  step_el_q, step_el_d;
  logic [OW-1:0]  off_el_q, off_el_d;
  logic [OW-1:0]  off_lim_q, off_lim_d;   // auto-off limit in ms, 0 disables
  logic [7:0]     step_val_q, step_val_d;
  logic           rev_q, rev_d;
  logic [7:0]     level_q, level_d;
  logic [7:0]     red_q, red_d, green_q, green_d, blue_q, blue_d;

  logic               out_valid_q, out_valid_d;
  lle_pkg::out_word_t out_word_q, out_word_d;

  lle_pkg::div_req_t div_req;
  lle_pkg::div_rsp_t div_rsp;

  logic           in_acc;
  lle_pkg::mode_e act_mode;
  logic [7:0]     speed_eff, peak, fade_div;

  // tick datapath
  logic [OW-1:0]  off_inc;
  logic [PW-1:0]  st_inc;
  logic           auto_off, step_hit;
  logic [7:0]     fd_v1, fd_v2;
  logic           fd_r1, fd_r2;
  logic [8:0]     fd_sum;
  logic [7:0]     rb_v, rb_w, rb_w3;
  logic [7:0]     rb_r, rb_g, rb_b;

  function automatic logic [7:0] times3(input logic [7:0] x);
    return 8'({1'b0, x} + {x, 1'b0});
  endfunction

  lle_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign in_ready_o  = (st_q == lle_pkg::ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  assign speed_eff = (speed_q == '0) ? 8'd1 : speed_q;
  assign peak      = (set_bri_q > min_fade_q) ? set_bri_q : min_fade_q;
  assign fade_div  = (peak == '0) ? 8'd1 : peak;

  // mode requested by activate; undefined codes read as off, test mode turns off into on
  always_comb begin
    if (lamp_mode_q > 3'(lle_pkg::MODE_RAINBOW)) begin
      act_mode = lle_pkg::MODE_OFF;
    end else begin
      act_mode = lle_pkg::mode_e'(lamp_mode_q);
    end
    if (in_word_i.test_mode && act_mode == lle_pkg::MODE_OFF) begin
      act_mode = lle_pkg::MODE_ON;
    end
  end

  // tick arithmetic: timers, fade and rainbow step
  always_comb begin
    off_inc  = (off_el_q != '1) ? off_el_q + 1'b1 : off_el_q;
    st_inc   = (step_el_q != '1) ? step_el_q + 1'b1 : step_el_q;
    auto_off = (off_lim_q != '0) && (off_inc >= off_lim_q);
    step_hit = (period_q != '0) && (st_inc >= period_q);

    // fade: clamp at peak and turn down, turn up at the floor
    if (step_val_q >= peak) begin
      fd_v1 = peak;
      fd_r1 = 1'b1;
    end else begin
      fd_v1 = step_val_q;
      fd_r1 = rev_q;
    end
    fd_r2  = (fd_v1 <= lle_pkg::FADE_STEP) ? 1'b0 : fd_r1;
    fd_sum = {1'b0, fd_v1} + {1'b0, lle_pkg::FADE_STEP};
    if (fd_r2) begin
      fd_v2 = fd_v1 - lle_pkg::FADE_STEP;
    end else begin
      fd_v2 = fd_sum[8] ? 8'hFF : fd_sum[7:0];
    end

    // rainbow wheel in three thirds
    rb_v = step_val_q + lle_pkg::FADE_STEP;
    if (rb_v < lle_pkg::WHEEL_THIRD) begin
      rb_w  = rb_v;
      rb_w3 = times3(rb_w);
      rb_r  = rb_w3;
      rb_g  = 8'hFF - rb_w3;
      rb_b  = '0;
    end else if (rb_v < lle_pkg::WHEEL_TWO_THIRD) begin
      rb_w  = rb_v - lle_pkg::WHEEL_THIRD;
      rb_w3 = times3(rb_w);
      rb_r  = 8'hFF - rb_w3;
      rb_g  = '0;
      rb_b  = rb_w3;
    end else begin
      rb_w  = rb_v - lle_pkg::WHEEL_TWO_THIRD;
      rb_w3 = times3(rb_w);
      rb_r  = '0;
      rb_g  = rb_w3;
      rb_b  = 8'hFF - rb_w3;
    end
  end

  // sequencer
  always_comb begin
    st_d        = st_q;
    cur_mode_d  = cur_mode_q;
    period_d    = period_q;
    step_el_d   = step_el_q;
    off_el_d    = off_el_q;
    off_lim_d   = off_lim_q;
    step_val_d  = step_val_q;
    rev_d       = rev_q;
    level_d     = level_q;
    red_d       = red_q;
    green_d     = green_q;
    blue_d      = blue_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_word_d  = out_word_q;
    div_req     = '0;

    unique case (st_q)
      lle_pkg::ST_IDLE: begin
        if (in_acc) begin
          st_d = lle_pkg::ST_DONE;
          unique case (lle_pkg::cmd_e'(in_word_i.command))
            lle_pkg::CMD_TICK: begin
              if (cur_mode_q != lle_pkg::MODE_OFF) begin
                off_el_d = off_inc;
                if (auto_off) begin
                  cur_mode_d = lle_pkg::MODE_OFF;
                end else if (period_q != '0) begin
                  step_el_d = step_hit ? '0 : st_inc;
                  if (step_hit) begin
                    case (cur_mode_q)
                      lle_pkg::MODE_FLASH: begin
                        rev_d   = !rev_q;
                        level_d = rev_q ? set_bri_q : 8'd0;
                      end
                      lle_pkg::MODE_FADE: begin
                        rev_d      = fd_r2;
                        step_val_d = fd_v2;
                        level_d    = fd_v2;
                      end
                      lle_pkg::MODE_RAINBOW: begin
                        step_val_d = rb_v;
                        red_d      = rb_r;
                        green_d    = rb_g;
                        blue_d     = rb_b;
                      end
                      default: ;
                    endcase
                  end
                end
              end
            end
            lle_pkg::CMD_ACTIVATE: begin
              if (act_mode != cur_mode_q) begin
                cur_mode_d = act_mode;
                level_d    = set_bri_q;
                if (act_mode != lle_pkg::MODE_RAINBOW) begin
                  red_d   = base_r_q;
                  green_d = base_g_q;
                  blue_d  = base_b_q;
                end
                off_lim_d  = in_word_i.test_mode ? '0 :
                             OW'(off_delay_q) * OW'(lle_pkg::MS_PER_MIN);
                off_el_d   = '0;
                step_el_d  = '0;
                rev_d      = 1'b0;
                step_val_d = (act_mode == lle_pkg::MODE_FADE) ? set_bri_q : 8'd0;
                period_d   = '0;
                div_req.divisor = speed_eff;
                case (act_mode)
                  lle_pkg::MODE_FLASH: begin
                    div_req.start    = 1'b1;
                    div_req.dividend = lle_pkg::FLASH_DIVIDEND;
                    st_d             = lle_pkg::ST_DIV1;
                  end
                  lle_pkg::MODE_FADE: begin
                    div_req.start    = 1'b1;
                    div_req.dividend = lle_pkg::FADE_DIVIDEND;
                    st_d             = lle_pkg::ST_DIV1;
                  end
                  lle_pkg::MODE_RAINBOW: begin
                    div_req.start    = 1'b1;
                    div_req.dividend = lle_pkg::RAINBOW_DIVIDEND;
                    st_d             = lle_pkg::ST_DIV1;
                  end
                  default: ;
                endcase
              end
            end
            lle_pkg::CMD_DEACTIVATE: begin
              cur_mode_d = lle_pkg::MODE_OFF;
            end
            default: ;  // unused command code: no change
          endcase
        end
      end
      lle_pkg::ST_DIV1: begin
        if (div_rsp.done) begin
          if (cur_mode_q == lle_pkg::MODE_FADE) begin
            // second pass divides by the fade peak
            div_req.start    = 1'b1;
            div_req.dividend = div_rsp.quotient;
            div_req.divisor  = fade_div;
            st_d             = lle_pkg::ST_DIV2;
          end else begin
            period_d = div_rsp.quotient;
            st_d     = lle_pkg::ST_DONE;
          end
        end
      end
      lle_pkg::ST_DIV2: begin
        if (div_rsp.done) begin
          period_d = div_rsp.quotient;
          st_d     = lle_pkg::ST_DONE;
        end
      end
      lle_pkg::ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d                = 1'b1;
          out_word_d.lamp_on         = (cur_mode_q != lle_pkg::MODE_OFF);
          out_word_d.active_mode     = cur_mode_q;
          out_word_d.out_brightness  = level_q;
          out_word_d.out_red         = red_q;
          out_word_d.out_green       = green_q;
          out_word_d.out_blue        = blue_q;
          st_d                       = lle_pkg::ST_IDLE;
        end
      end
      default: st_d = lle_pkg::ST_IDLE;
    endcase
  end

  // config write port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lamp_mode_q <= 3'(lle_pkg::MODE_OFF);
      set_bri_q   <= 8'd255;
      speed_q     <= 8'd1;
      off_delay_q <= 8'd0;
      min_fade_q  <= 8'd25;
      base_r_q    <= 8'd255;
      base_g_q    <= 8'd255;
      base_b_q    <= 8'd255;
    end else if (cfg_we_i) begin
      unique case (lle_pkg::cfg_idx_e'(cfg_idx_i))
        lle_pkg::REG_LAMP_MODE:  lamp_mode_q <= cfg_data_i[2:0];
        lle_pkg::REG_BRIGHTNESS: set_bri_q   <= cfg_data_i;
        lle_pkg::REG_SPEED:      speed_q     <= cfg_data_i;
        lle_pkg::REG_OFF_DELAY:  off_delay_q <= cfg_data_i;
        lle_pkg::REG_MIN_FADE:   min_fade_q  <= cfg_data_i;
        lle_pkg::REG_BASE_RED:   base_r_q    <= cfg_data_i;
        lle_pkg::REG_BASE_GREEN: base_g_q    <= cfg_data_i;
        lle_pkg::REG_BASE_BLUE:  base_b_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= lle_pkg::ST_IDLE;
      cur_mode_q  <= lle_pkg::MODE_OFF;
      period_q    <= '0;
      step_el_q   <= '0;
      off_el_q    <= '0;
      off_lim_q   <= '0;
      step_val_q  <= '0;
      rev_q       <= 1'b0;
      level_q     <= '0;
      red_q       <= '0;
      green_q     <= '0;
      blue_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      cur_mode_q  <= cur_mode_d;
      period_q    <= period_d;
      step_el_q   <= step_el_d;
      off_el_q    <= off_el_d;
      off_lim_q   <= off_lim_d;
      step_val_q  <= step_val_d;
      rev_q       <= rev_d;
      level_q     <= level_d;
      red_q       <= red_d;
      green_q     <= green_d;
      blue_q      <= blue_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_word_q <= out_word_d;
  end

  a_div_done_in_div_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (st_q == lle_pkg::ST_DIV1 || st_q == lle_pkg::ST_DIV2))
    else $error("divider result outside a divide state");

  a_step_timer_below_period: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (period_q != '0) |-> (step_el_q < period_q))
    else $error("step timer passed the step period");

  a_second_div_only_fade: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == lle_pkg::ST_DIV2) |-> (cur_mode_q == lle_pkg::MODE_FADE))
    else $error("second divide outside fade mode");

endmodule

// ----- src/lle_div.sv -----
// Restoring divider, one quotient bit per cycle. Divisor must be nonzero.
module lle_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lle_pkg::div_req_t req_i,
  output lle_pkg::div_rsp_t rsp_o
);

  localparam int unsigned QW    = lle_pkg::PERIOD_W;
  localparam int unsigned DW    = lle_pkg::DVS_W;
  localparam int unsigned CNT_W = $clog2(QW);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [QW-1:0]    quo_q, quo_d;
  logic [DW-1:0]    rem_q, rem_d;
  logic [DW-1:0]    dvs_q, dvs_d;
  logic [DW:0]      trial;
  logic [DW:0]      diff;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    trial  = {rem_q, quo_q[QW-1]};
    diff   = trial - {1'b0, dvs_q};
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(QW - 1);
      quo_d  = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      // partial remainder stays below the divisor, so DW bits hold it
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = diff[DW-1:0];
        quo_d = {quo_q[QW-2:0], 1'b1};
      end else begin
        rem_d = trial[DW-1:0];
        quo_d = {quo_q[QW-2:0], 1'b0};
      end
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q)
    else $error("divider restarted while busy");

  a_done_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.done |-> ($past(busy_q) && ($past(cnt_q) == '0)))
    else $error("divider done without final iteration");

  a_divisor_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (dvs_q != '0))
    else $error("divider running with zero divisor");

endmodule

// ----- tb/led_lamp_effect_engine_tb.sv -----
`timescale 1ns / 100ps

module led_lamp_effect_engine_tb;
  import lle_pkg::*;

  // Command code outside cmd_e: the block must treat it as a no-op.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // Timeout. The slowest correct run is the two auto-off runs (120k ticks)
  // plus the random sessions.
  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  // Long receiver hold-off, long enough to back the block up into its input.
  localparam int unsigned HOLD_CYCLES = 400;
  // Settling time after the last status word: covers the slowest activate.
  localparam int unsigned DRAIN_CYCLES = 60;
  localparam int unsigned PHASE_WORDS = 440;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_word_t  in_word = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_word;
  logic      cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  // Stimulus and checking bookkeeping
  in_word_t  word_q[$];          // command words waiting for the driver
  out_word_t lamp_status_q[$];   // predicted status words, oldest first
  bit        word_taken = 1'b0;  // input handshake seen at the last rising edge
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_on = 1'b0;
  int unsigned hold_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned out_cnt = 0;
  int unsigned err_cnt = 0;
  int unsigned sent_cnt = 0;

  // Predictor copy of the register file (reset values)
  logic [2:0] reg_mode = 3'd0;
  logic [7:0] reg_bri = 8'hFF;
  logic [7:0] reg_speed = 8'd1;
  logic [7:0] reg_off = 8'd0;
  logic [7:0] reg_min_fade = 8'd25;
  logic [7:0] reg_red = 8'hFF;
  logic [7:0] reg_green = 8'hFF;
  logic [7:0] reg_blue = 8'hFF;

  // Predictor copy of the lamp state (all zero after reset)
  mode_e               lamp_mode_now = MODE_OFF;
  logic [PERIOD_W-1:0] step_len = '0;   // ticks per effect step, 0 = no stepping
  logic [PERIOD_W-1:0] step_cnt = '0;
  logic [OFF_W-1:0]    on_ms = '0;      // ms since activation, saturating
  logic [7:0]          off_min = '0;    // auto-off limit in minutes, 0 = never
  logic [7:0]          wave = '0;       // fade level or rainbow hue
  logic                falling = 1'b0;  // flash phase / fade direction
  logic [7:0]          level_now = '0;
  logic [7:0]          red_now = '0;
  logic [7:0]          green_now = '0;
  logic [7:0]          blue_now = '0;

  led_lamp_effect_engine u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_word_i  (in_word),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_word_o (out_word),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------
  // Lamp predictor
  // ---------------------------------------------------------------------

  // Fade peak and fade period divisor; brightness is read live.
  function automatic int fade_top();
    return (reg_bri > reg_min_fade) ? int'(reg_bri) : int'(reg_min_fade);
  endfunction

  function automatic void effect_step();
    int top;
    int hue;
    case (lamp_mode_now)
      MODE_FLASH: begin
        falling = ~falling;
        level_now = falling ? 8'h00 : reg_bri;
      end
      MODE_FADE: begin
        top = fade_top();
        // turn down at the peak, turn up near the floor
        if (int'(wave) >= top) begin
          wave = 8'(top);
          falling = 1'b1;
        end
        if (wave <= FADE_STEP) falling = 1'b0;
        if (falling) wave = wave - FADE_STEP;
        else if (int'(wave) + int'(FADE_STEP) > 255) wave = 8'hFF;
        else wave = wave + FADE_STEP;
        level_now = wave;
      end
      MODE_RAINBOW: begin
        wave = wave + FADE_STEP;  // wraps in 8 bits
        hue = int'(wave);
        if (hue < int'(WHEEL_THIRD)) begin
          red_now = 8'(hue * 3);
          green_now = 8'(255 - hue * 3);
          blue_now = 8'h00;
        end else if (hue < int'(WHEEL_TWO_THIRD)) begin
          hue = hue - int'(WHEEL_THIRD);
          red_now = 8'(255 - hue * 3);
          green_now = 8'h00;
          blue_now = 8'(hue * 3);
        end else begin
          hue = hue - int'(WHEEL_TWO_THIRD);
          red_now = 8'h00;
          green_now = 8'(hue * 3);
          blue_now = 8'(255 - hue * 3);
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void lamp_activate(logic test);
    mode_e target;
    int spd;
    int dv;
    // lamp_mode 5..7 reads as off; test mode turns off into on
    target = (reg_mode > MODE_RAINBOW) ? MODE_OFF : mode_e'(reg_mode);
    if (test && target == MODE_OFF) target = MODE_ON;
    if (target != lamp_mode_now) begin
      lamp_mode_now = target;
      level_now = reg_bri;
      if (target != MODE_RAINBOW) begin
        red_now = reg_red;
        green_now = reg_green;
        blue_now = reg_blue;
      end
      off_min = test ? 8'd0 : reg_off;
      on_ms = '0;
      step_cnt = '0;
      falling = 1'b0;
      wave = (target == MODE_FADE) ? reg_bri : 8'd0;
      spd = (reg_speed == 8'd0) ? 1 : int'(reg_speed);
      case (target)
        MODE_FLASH: step_len = PERIOD_W'(int'(FLASH_DIVIDEND) / spd);
        MODE_FADE: begin
          dv = fade_top();
          if (dv == 0) dv = 1;
          step_len = PERIOD_W'((int'(FADE_DIVIDEND) / spd) / dv);
        end
        MODE_RAINBOW: step_len = PERIOD_W'(int'(RAINBOW_DIVIDEND) / spd);
        default: step_len = '0;
      endcase
    end
  endfunction

  function automatic void lamp_tick();
    if (lamp_mode_now != MODE_OFF) begin
      if (on_ms != '1) on_ms++;
      if (off_min != 8'd0 && int'(on_ms) >= int'(off_min) * int'(MS_PER_MIN)) begin
        lamp_mode_now = MODE_OFF;
      end else if (step_len != '0) begin
        if (step_cnt != '1) step_cnt++;
        if (step_cnt >= step_len) begin
          effect_step();
          step_cnt = '0;
        end
      end
    end
  endfunction

  // Applies one command word and returns the status word it must produce.
  function automatic out_word_t lamp_predict(in_word_t w);
    out_word_t st;
    case (w.command)
      CMD_TICK:       lamp_tick();
      CMD_ACTIVATE:   lamp_activate(w.test_mode);
      CMD_DEACTIVATE: lamp_mode_now = MODE_OFF;
      default: ;  // unused code: no state change
    endcase
    st.lamp_on = (lamp_mode_now != MODE_OFF);
    st.active_mode = lamp_mode_now;
    st.out_brightness = level_now;
    st.out_red = red_now;
    st.out_green = green_now;
    st.out_blue = blue_now;
    return st;
  endfunction

  // ---------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------

  task automatic report_mismatch(string msg);
    if (err_cnt < 50) $display("ERROR: %s", msg);
    err_cnt++;
  endtask

  task automatic check_field(string name, logic [7:0] got_v, logic [7:0] want_v);
    if (got_v !== want_v) begin
      report_mismatch($sformatf("status word %0d: %s = %0d, expected %0d",
                                out_cnt, name, got_v, want_v));
    end
  endtask

  // Rising edge: count cycles, watch both handshakes. The output side is
  // checked before the input side so a stray word can't consume a fresh
  // expectation from the same edge.
  always @(posedge clk_i) begin
    out_word_t want;
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("TIMEOUT after %0d cycles, %0d status words pending",
               cycle_cnt, lamp_status_q.size());
      $display("DONE: errors detected");
      $finish;
    end else if (rst_ni) begin
      if (out_valid && out_ready) begin
        if (lamp_status_q.size() == 0) begin
          report_mismatch($sformatf("status word %0d arrived with none expected", out_cnt));
        end else begin
          want = lamp_status_q.pop_front();
          check_field("lamp_on", out_word.lamp_on, want.lamp_on);
          check_field("active_mode", out_word.active_mode, want.active_mode);
          check_field("out_brightness", out_word.out_brightness, want.out_brightness);
          check_field("out_red", out_word.out_red, want.out_red);
          check_field("out_green", out_word.out_green, want.out_green);
          check_field("out_blue", out_word.out_blue, want.out_blue);
        end
        out_cnt++;
      end
      word_taken = in_valid && in_ready;
      if (word_taken) lamp_status_q.push_back(lamp_predict(in_word));
    end
  end

  // ---------------------------------------------------------------------
  // Driver and receiver, both on the falling edge
  // ---------------------------------------------------------------------

  // Valid stays up with the same word until taken; a new word is only
  // offered after the previous one went through.
  always @(negedge clk_i) begin
    if (!in_valid || word_taken) begin
      if (word_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_word <= word_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // One long hold-off when requested, random stalls otherwise.
  always @(negedge clk_i) begin
    if (hold_on && hold_cnt < HOLD_CYCLES) begin
      out_ready <= 1'b0;
      hold_cnt <= hold_cnt + 1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  task automatic send(logic [1:0] cmd, logic test);
    in_word_t w;
    w.command = cmd;
    w.test_mode = test;
    word_q.push_back(w);
    sent_cnt++;
  endtask

  task automatic send_ticks(int n);
    for (int k = 0; k < n; k++) send(CMD_TICK, 1'($urandom_range(0, 1)));
  endtask

  // Block is idle once nothing is queued, offered or outstanding.
  task automatic wait_drained();
    do @(posedge clk_i);
    while (word_q.size() != 0 || in_valid || lamp_status_q.size() != 0);
  endtask

  // Register write at a falling edge; the predictor copy follows at once
  // since the block is idle. end_writes drops the strobe.
  task automatic set_reg(cfg_idx_e idx, logic [7:0] val);
    @(negedge clk_i);
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_data = val;
    case (idx)
      REG_LAMP_MODE:  reg_mode = val[2:0];
      REG_BRIGHTNESS: reg_bri = val;
      REG_SPEED:      reg_speed = val;
      REG_OFF_DELAY:  reg_off = val;
      REG_MIN_FADE:   reg_min_fade = val;
      REG_BASE_RED:   reg_red = val;
      REG_BASE_GREEN: reg_green = val;
      REG_BASE_BLUE:  reg_blue = val;
    endcase
  endtask

  task automatic end_writes();
    @(negedge clk_i);
    cfg_we = 1'b0;
  endtask

  function automatic logic [7:0] any_byte();
    case ($urandom_range(0, 5))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic maybe_set(cfg_idx_e idx, logic [7:0] val);
    if ($urandom_range(0, 3) != 0) set_reg(idx, val);
  endtask

  // New settings for a session. Speeds are steered so the effect actually
  // steps within a few dozen ticks; now and then anything goes.
  task automatic pick_settings();
    logic [2:0] m;
    logic [7:0] bri;
    logic [7:0] minf;
    logic [7:0] spd;
    int top;
    int quo;
    m = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(0, 7)) : 3'($urandom_range(1, 4));
    bri = any_byte();
    minf = ($urandom_range(0, 7) == 0) ? any_byte() : 8'($urandom_range(5, 255));
    top = (bri > minf) ? int'(bri) : int'(minf);
    if (top == 0) top = 1;
    case (m)
      MODE_FLASH:   spd = 8'($urandom_range(120, 255));
      MODE_RAINBOW: spd = 8'($urandom_range(25, 255));
      default: begin
        quo = int'(FADE_DIVIDEND) / (top * $urandom_range(1, 6));
        spd = (quo > 255) ? 8'hFF : (quo < 1) ? 8'd1 : 8'(quo);
      end
    endcase
    if ($urandom_range(0, 9) == 0) spd = any_byte();
    set_reg(REG_LAMP_MODE, {5'd0, m});
    maybe_set(REG_BRIGHTNESS, bri);
    maybe_set(REG_SPEED, spd);
    maybe_set(REG_OFF_DELAY, $urandom_range(0, 1) ? 8'h00 : any_byte());
    maybe_set(REG_MIN_FADE, minf);
    maybe_set(REG_BASE_RED, any_byte());
    maybe_set(REG_BASE_GREEN, any_byte());
    maybe_set(REG_BASE_BLUE, any_byte());
    end_writes();
  endtask

  // Session: fresh settings, usually an activate, then mostly ticks with a
  // sprinkle of re-activates, deactivates and the unused code. Sessions that
  // skip the activate keep running on the old period with new live values.
  task automatic run_session();
    int n;
    int r;
    pick_settings();
    n = $urandom_range(30, 70);
    if ($urandom_range(0, 9) < 7) send(CMD_ACTIVATE, 1'($urandom_range(0, 1)));
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 86) send(CMD_TICK, 1'($urandom_range(0, 1)));
      else if (r < 92) send(CMD_ACTIVATE, 1'($urandom_range(0, 1)));
      else if (r < 96) send(CMD_DEACTIVATE, 1'($urandom_range(0, 1)));
      else send(CMD_UNUSED, 1'($urandom_range(0, 1)));
    end
    wait_drained();
  endtask

  task automatic run_phase(int unsigned idle_pct, int unsigned stall_pct);
    int unsigned first;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    first = sent_cnt;
    while (sent_cnt - first < PHASE_WORDS) run_session();
  endtask

  // ---------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------
  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset registers: tick and deactivate while off do nothing, unused code
    // does nothing, activate of mode off is a no-op unless test mode forces on,
    // repeated activate into the same mode changes nothing.
    send(CMD_TICK, 1'b0);
    send(CMD_DEACTIVATE, 1'b0);
    send(CMD_UNUSED, 1'b1);
    send(CMD_ACTIVATE, 1'b0);
    send(CMD_ACTIVATE, 1'b1);
    send(CMD_ACTIVATE, 1'b1);
    send(CMD_TICK, 1'b1);
    send(CMD_DEACTIVATE, 1'b1);
    wait_drained();

    // lamp_mode above rainbow reads as off
    set_reg(REG_LAMP_MODE, 8'd7);
    end_writes();
    send(CMD_ACTIVATE, 1'b0);
    send(CMD_ACTIVATE, 1'b1);
    wait_drained();

    // Flash at top speed: period 9, so one step lands inside ten ticks.
    set_reg(REG_LAMP_MODE, 8'(MODE_FLASH));
    set_reg(REG_SPEED, 8'hFF);
    set_reg(REG_BASE_RED, 8'h00);
    set_reg(REG_BASE_GREEN, 8'h5A);
    set_reg(REG_BASE_BLUE, 8'hA5);
    end_writes();
    send(CMD_ACTIVATE, 1'b0);
    send_ticks(10);
    send(CMD_DEACTIVATE, 1'b0);
    wait_drained();

    // Fade with peak from min_fade just above brightness: the climb
    // saturates at 255, turns down at the peak and back up near the floor.
    set_reg(REG_LAMP_MODE, 8'(MODE_FADE));
    set_reg(REG_BRIGHTNESS, 8'd252);
    set_reg(REG_MIN_FADE, 8'd253);
    set_reg(REG_SPEED, 8'd98);
    end_writes();
    send(CMD_ACTIVATE, 1'b0);
    send_ticks(110);
    wait_drained();

    // Fade divisor of zero: brightness and min_fade both 0
    set_reg(REG_BRIGHTNESS, 8'd0);
    set_reg(REG_MIN_FADE, 8'd0);
    set_reg(REG_SPEED, 8'hFF);
    end_writes();
    send(CMD_DEACTIVATE, 1'b0);
    send(CMD_ACTIVATE, 1'b0);
    send_ticks(200);
    wait_drained();

    // Rainbow with speed 0 (acts as 1): one step after 250 ticks
    set_reg(REG_LAMP_MODE, 8'(MODE_RAINBOW));
    set_reg(REG_SPEED, 8'd0);
    set_reg(REG_BRIGHTNESS, 8'd128);
    end_writes();
    send(CMD_DEACTIVATE, 1'b0);
    send(CMD_ACTIVATE, 1'b0);
    send_ticks(252);
    wait_drained();

    // Rainbow period rounds down to zero: never steps
    set_reg(REG_SPEED, 8'hFF);
    end_writes();
    send(CMD_DEACTIVATE, 1'b0);
    send(CMD_ACTIVATE, 1'b1);
    send_ticks(20);
    wait_drained();

    // Auto-off after one minute. Test mode ignores the delay entirely;
    // a normal activate switches off on the 60000th tick, later ticks
    // are ignored.
    set_reg(REG_LAMP_MODE, 8'(MODE_FLASH));
    set_reg(REG_BRIGHTNESS, 8'd200);
    set_reg(REG_OFF_DELAY, 8'd1);
    end_writes();
    send(CMD_DEACTIVATE, 1'b0);
    send(CMD_ACTIVATE, 1'b1);
    send_ticks(int'(MS_PER_MIN) + 5);
    wait_drained();
    send(CMD_DEACTIVATE, 1'b0);
    send(CMD_ACTIVATE, 1'b0);
    send_ticks(int'(MS_PER_MIN) + 5);
    wait_drained();

    // Random sessions. The first phase also opens with a long receiver
    // hold-off while the driver keeps offering, to back the block up.
    hold_on = 1'b1;
    run_phase(0, 0);
    run_phase(59, 0);
    run_phase(0, 59);
    run_phase(13, 13);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/lle_pkg.sv
src/lle_div.sv
src/led_lamp_effect_engine.sv
tb/led_lamp_effect_engine_tb.sv
